// ===== design/power_bus_sequencer_with_average_defines.svh =====
// Assertion macros for the checker file of the power bus sequencer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef POWER_BUS_SEQUENCER_WITH_AVERAGE_DEFINES_SVH
`define POWER_BUS_SEQUENCER_WITH_AVERAGE_DEFINES_SVH

// The antecedent in one cycle implies the consequent in the next cycle.
`define PBSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define PBSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/pbsa_pkg.sv =====
`default_nettype none

package pbsa_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned WINDOW_LEN  = 255;
  localparam int unsigned LEVEL_BITS  = SAMPLE_BITS + 1;
  localparam int unsigned FULL_SCALE  = 1 << SAMPLE_BITS;
  localparam int unsigned HEAD_BITS   = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_BITS    = $clog2(WINDOW_LEN * FULL_SCALE + 1);

  // Floor division by the window length as a multiply by a rounded-up reciprocal.
  // With eight extra fraction bits the error stays below one for every sum.
  localparam int unsigned DIV_SHIFT = SUM_BITS + 8;
  localparam int unsigned PROD_BITS = SUM_BITS + DIV_SHIFT;
  localparam logic [DIV_SHIFT-1:0] DIV_MUL =
    DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = LEVEL_BITS'(FULL_SCALE);
  localparam logic [SUM_BITS-1:0]   SUM_FULL   = SUM_BITS'(WINDOW_LEN * FULL_SCALE);

  localparam logic [SAMPLE_BITS-1:0] BUS_THR_RESET  = 12'h0A80;
  localparam logic [SAMPLE_BITS-1:0] KILL_THR_RESET = 12'h09E5;

  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BUS_THR  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KILL_THR = 2'd1;

  localparam logic [1:0] PS_OFF      = 2'd0;
  localparam logic [1:0] PS_STARTUP  = 2'd1;
  localparam logic [1:0] PS_ON       = 2'd2;
  localparam logic [1:0] PS_SHUTDOWN = 2'd3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] power_sample;
    logic [SAMPLE_BITS-1:0] thruster_sample;
    logic                   kill_pressed;
    logic                   remote_active;
  } pbsa_in_t;

  typedef struct packed {
    logic                  relay_on;
    logic                  electronics_on;
    logic                  thruster_killed;
    logic [LEVEL_BITS-1:0] filtered_level;
    logic [1:0]            power_state;
  } pbsa_out_t;

endpackage

`default_nettype wire

// ===== design/power_bus_sequencer_with_average.sv =====
// Each result word is registered into the output slot, or into the skid slot while the
// output holds a stalled word; a word queued behind a stalled one waits for it to leave.
// Throughput: one word per cycle unless in_stall is up; the ring memory's single write and
// read port each carry one access per tick, and a two-entry output buffer parks a word in a stall.
// Reset (synchronous, rst_n low): state off, relay and electronics open, thresholds to
// defaults, running sum to full scale, and all ring valid bits cleared in the same cycle.
`default_nettype none

module power_bus_sequencer_with_average (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire pbsa_pkg::pbsa_in_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output pbsa_pkg::pbsa_out_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pbsa_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [pbsa_pkg::SAMPLE_BITS-1:0]  cfg_data
);

  // Sequencer states, coded to match the power_state field.
  typedef enum logic [1:0] {
    ST_OFF      = pbsa_pkg::PS_OFF,
    ST_STARTUP  = pbsa_pkg::PS_STARTUP,
    ST_ON       = pbsa_pkg::PS_ON,
    ST_SHUTDOWN = pbsa_pkg::PS_SHUTDOWN
  } state_t;

  // A finished result word is held with the raw running sum; the average is
  // derived from it at the output so the decision path carries no division.
  typedef struct packed {
    logic                          relay;
    logic                          electronics;
    logic                          killed;
    logic [pbsa_pkg::SUM_BITS-1:0] sum;
    state_t                        state;
  } result_t;

  // Control and sequencer state.
  state_t                         state_r, state_nxt;
  logic                           fail_r, fail_nxt;
  logic                           armed_r, armed_nxt;
  logic                           relay_r, relay_nxt;
  logic                           elec_r, elec_nxt;
  logic                           killed_r, killed_nxt;
  logic [pbsa_pkg::HEAD_BITS-1:0] head_r, head_nxt;
  logic [pbsa_pkg::SUM_BITS-1:0]  sum_r, sum_nxt;
  logic [pbsa_pkg::WINDOW_LEN-1:0] valid_r, valid_nxt;

  // Configuration. The bus threshold is also kept scaled by the window length,
  // so the average test becomes a compare against the running sum.
  logic [pbsa_pkg::SAMPLE_BITS-1:0] bus_thr_r, bus_thr_nxt;
  logic [pbsa_pkg::SAMPLE_BITS-1:0] kill_thr_r, kill_thr_nxt;
  logic [pbsa_pkg::SUM_BITS-1:0]    bus_thr_w_r, bus_thr_w_nxt;

  // Output buffer: the visible word and one skid word behind it.
  result_t out_word_r, out_word_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t skid_word_r, skid_word_nxt;
  logic    skid_valid_r, skid_valid_nxt;

  // Ring memory interface.
  logic                             ram_wr_en;
  logic [pbsa_pkg::HEAD_BITS-1:0]   ram_rd_addr;
  logic [pbsa_pkg::SAMPLE_BITS-1:0] ram_rd_data;

  logic                             accept;
  logic                             pop;
  logic                             released;
  logic [pbsa_pkg::HEAD_BITS-1:0]   head_inc;
  logic [pbsa_pkg::LEVEL_BITS-1:0]  old_sample;
  logic [pbsa_pkg::SUM_BITS-1:0]    sum_push;
  result_t                          res_new;
  logic [pbsa_pkg::PROD_BITS-1:0]   div_prod;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign pop       = out_valid_r && !out_stall;

  // The read address is the head value of the next cycle, so the registered
  // read data always holds the entry under the current head. A write only
  // happens when the head moves on, so read and write never meet on one entry.
  assign ram_rd_addr = rst_n ? head_nxt : '0;

  pbsa_ring_ram u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (head_r),
    .wr_data (in_data.power_sample),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // An entry not written since the last refill counts as full scale.
  assign old_sample = valid_r[head_r] ? pbsa_pkg::LEVEL_BITS'(ram_rd_data)
                                      : pbsa_pkg::LEVEL_FULL;
  assign sum_push   = sum_r - pbsa_pkg::SUM_BITS'(old_sample)
                      + pbsa_pkg::SUM_BITS'(in_data.power_sample);
  assign head_inc   = (head_r == pbsa_pkg::HEAD_BITS'(pbsa_pkg::WINDOW_LEN - 1))
                      ? '0 : head_r + 1'b1;

  // The switch is armed when it is seen active in the off or on state; seeing it
  // inactive while armed is a release.
  assign released = armed_r && !in_data.remote_active;

  // Sequencer next state.
  always_comb begin
    state_nxt  = state_r;
    fail_nxt   = fail_r;
    armed_nxt  = armed_r;
    relay_nxt  = relay_r;
    elec_nxt   = elec_r;
    killed_nxt = killed_r;
    head_nxt   = head_r;
    sum_nxt    = sum_r;
    valid_nxt  = valid_r;
    ram_wr_en  = 1'b0;
    if (accept) begin
      unique case (state_r)
        ST_OFF: begin
          armed_nxt = in_data.remote_active;
          if ((in_data.power_sample >= bus_thr_r) || released) begin
            state_nxt = ST_STARTUP;
          end
        end
        ST_STARTUP: begin
          if (!in_data.kill_pressed) begin
            relay_nxt = 1'b1;
            elec_nxt  = 1'b1;
            fail_nxt  = 1'b0;
            state_nxt = ST_ON;
          end else begin
            fail_nxt  = 1'b1;
            state_nxt = ST_OFF;
          end
          // Refill the window: every entry reads as full scale again.
          valid_nxt = '0;
          sum_nxt   = pbsa_pkg::SUM_FULL;
        end
        ST_ON: begin
          ram_wr_en          = 1'b1;
          valid_nxt[head_r]  = 1'b1;
          head_nxt           = head_inc;
          sum_nxt            = sum_push;
          killed_nxt         = in_data.thruster_sample < kill_thr_r;
          armed_nxt          = in_data.remote_active;
          if (in_data.kill_pressed || (sum_push < bus_thr_w_r) || released) begin
            state_nxt = ST_SHUTDOWN;
          end
        end
        ST_SHUTDOWN: begin
          if (!fail_r) begin
            relay_nxt = 1'b0;
            state_nxt = ST_OFF;
          end else begin
            state_nxt = ST_ON;
          end
        end
        default: begin
          state_nxt = ST_OFF;
        end
      endcase
    end
  end

  // Configuration writes.
  always_comb begin
    bus_thr_nxt   = bus_thr_r;
    kill_thr_nxt  = kill_thr_r;
    bus_thr_w_nxt = bus_thr_w_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        pbsa_pkg::CFG_BUS_THR: begin
          bus_thr_nxt   = cfg_data;
          bus_thr_w_nxt = pbsa_pkg::SUM_BITS'(cfg_data * pbsa_pkg::WINDOW_LEN);
        end
        pbsa_pkg::CFG_KILL_THR: begin
          kill_thr_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Output buffer. A new word goes to the visible slot when it is free or
  // being emptied without a skid word, otherwise to the skid slot.
  always_comb begin
    res_new.relay       = relay_nxt;
    res_new.electronics = elec_nxt;
    res_new.killed      = killed_nxt;
    res_new.sum         = sum_nxt;
    res_new.state       = state_nxt;

    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_valid_r;
    skid_word_nxt  = skid_word_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_word_nxt = res_new;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r) begin
        out_word_nxt  = res_new;
        out_valid_nxt = 1'b1;
      end else begin
        skid_word_nxt  = res_new;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
    if (!rst_n) begin
      state_r      <= ST_OFF;
      fail_r       <= 1'b0;
      armed_r      <= 1'b0;
      relay_r      <= 1'b0;
      elec_r       <= 1'b0;
      killed_r     <= 1'b0;
      head_r       <= '0;
      sum_r        <= pbsa_pkg::SUM_FULL;
      valid_r      <= '0;
      bus_thr_r    <= pbsa_pkg::BUS_THR_RESET;
      kill_thr_r   <= pbsa_pkg::KILL_THR_RESET;
      bus_thr_w_r  <= pbsa_pkg::SUM_BITS'(pbsa_pkg::BUS_THR_RESET * pbsa_pkg::WINDOW_LEN);
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fail_r       <= fail_nxt;
      armed_r      <= armed_nxt;
      relay_r      <= relay_nxt;
      elec_r       <= elec_nxt;
      killed_r     <= killed_nxt;
      head_r       <= head_nxt;
      sum_r        <= sum_nxt;
      valid_r      <= valid_nxt;
      bus_thr_r    <= bus_thr_nxt;
      kill_thr_r   <= kill_thr_nxt;
      bus_thr_w_r  <= bus_thr_w_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // The window average is the floor of the held sum over the window length,
  // taken by a reciprocal multiply straight from the output register.
  assign div_prod = pbsa_pkg::PROD_BITS'(out_word_r.sum)
                    * pbsa_pkg::PROD_BITS'(pbsa_pkg::DIV_MUL);

  assign out_valid = out_valid_r;
  always_comb begin
    out_data.relay_on        = out_word_r.relay;
    out_data.electronics_on  = out_word_r.electronics;
    out_data.thruster_killed = out_word_r.killed;
    out_data.filtered_level  = div_prod[pbsa_pkg::DIV_SHIFT +: pbsa_pkg::LEVEL_BITS];
    out_data.power_state     = out_word_r.state;
  end

endmodule

`default_nettype wire

// ===== design/pbsa_ring_ram.sv =====
`default_nettype none

module pbsa_ring_ram (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [pbsa_pkg::HEAD_BITS-1:0]   wr_addr,
  input  wire logic [pbsa_pkg::SAMPLE_BITS-1:0] wr_data,
  input  wire logic [pbsa_pkg::HEAD_BITS-1:0]   rd_addr,
  output logic      [pbsa_pkg::SAMPLE_BITS-1:0] rd_data
);

  logic [pbsa_pkg::SAMPLE_BITS-1:0] mem [pbsa_pkg::WINDOW_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/pbsa_checker.sv =====
`default_nettype none
`include "power_bus_sequencer_with_average_defines.svh"

module pbsa_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire pbsa_pkg::pbsa_out_t out_data
);

  // A stalled result word stays put.
  `PBSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled word changed")

  // Every accepted word leaves a result word visible in the next cycle.
  `PBSA_ASSERT_NEXT(a_accept_result, in_valid && !in_stall, out_valid, "accepted word produced no result")

  // The electronics enable is never withdrawn once shown.
  `PBSA_ASSERT_NEXT(a_elec_sticky, out_valid && out_data.electronics_on, !out_valid || out_data.electronics_on, "electronics enable dropped")

  // The on state is only reached with the relay closed.
  `PBSA_ASSERT_NOW(a_on_relay, out_valid && (out_data.power_state == pbsa_pkg::PS_ON), out_data.relay_on, "on state with relay open")

endmodule

bind power_bus_sequencer_with_average pbsa_checker u_pbsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/pbsa_checker.sv =====
`timescale 1ns / 1ps

module pbsa_tb_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  pbsa_pkg::pbsa_in_t                in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  pbsa_pkg::pbsa_out_t               out_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pbsa_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [pbsa_pkg::SAMPLE_BITS-1:0]  cfg_data,
  output int                                error_count,
  output int                                pending_words,
  output int                                results_checked,
  output int                                good_startups,
  output int                                refused_startups,
  output int                                average_trips
);
  import pbsa_pkg::*;

  // Shadow copy of the sequencer state and its two thresholds.
  logic [1:0]             mode_q;
  logic                   start_failed_q;
  logic                   armed_q;
  logic                   killed_q;
  logic                   relay_q;
  logic                   elec_q;
  logic [LEVEL_BITS-1:0]  ring_q [WINDOW_LEN];
  logic [HEAD_BITS-1:0]   head_q;
  logic [SUM_BITS-1:0]    sum_q;
  logic [LEVEL_BITS-1:0]  level_q;
  logic [SAMPLE_BITS-1:0] bus_thr_q;
  logic [SAMPLE_BITS-1:0] kill_thr_q;

  pbsa_out_t sequencer_outputs_due[$];

  task automatic refill_window();
    for (int i = 0; i < WINDOW_LEN; i++) begin
      ring_q[i] = LEVEL_FULL;
    end
    sum_q   = SUM_FULL;
    level_q = LEVEL_FULL;
  endtask

  task automatic reset_sequencer();
    mode_q         = PS_OFF;
    start_failed_q = 1'b0;
    armed_q        = 1'b0;
    killed_q       = 1'b0;
    relay_q        = 1'b0;
    elec_q         = 1'b0;
    head_q         = '0;
    bus_thr_q      = BUS_THR_RESET;
    kill_thr_q     = KILL_THR_RESET;
    refill_window();
  endtask

  // The switch arms when seen active; seeing it inactive again is the release.
  function automatic logic remote_released(input logic active);
    if (!armed_q) begin
      armed_q = active;
      return 1'b0;
    end
    if (!active) begin
      armed_q = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_power(input logic [SAMPLE_BITS-1:0] sample);
    sum_q          = sum_q - ring_q[head_q] + sample;
    ring_q[head_q] = LEVEL_BITS'(sample);
    head_q         = (head_q == HEAD_BITS'(WINDOW_LEN - 1)) ? '0 : head_q + 1'b1;
    level_q        = LEVEL_BITS'(sum_q / WINDOW_LEN);
  endtask

  task automatic advance_sequencer(input pbsa_in_t w, output pbsa_out_t r);
    case (mode_q)
      PS_OFF: begin
        if (w.power_sample >= bus_thr_q) mode_q = PS_STARTUP;
        if (remote_released(w.remote_active)) mode_q = PS_STARTUP;
      end
      PS_STARTUP: begin
        if (!w.kill_pressed) begin
          relay_q        = 1'b1;
          elec_q         = 1'b1;
          start_failed_q = 1'b0;
          mode_q         = PS_ON;
          good_startups++;
        end else begin
          start_failed_q = 1'b1;
          mode_q         = PS_OFF;
          refused_startups++;
        end
        refill_window();
      end
      PS_ON: begin
        if (w.kill_pressed) mode_q = PS_SHUTDOWN;
        push_power(w.power_sample);
        if (level_q < bus_thr_q) begin
          mode_q = PS_SHUTDOWN;
          average_trips++;
        end
        killed_q = w.thruster_sample < kill_thr_q;
        if (remote_released(w.remote_active)) mode_q = PS_SHUTDOWN;
      end
      default: begin
        if (!start_failed_q) begin
          relay_q = 1'b0;
          mode_q  = PS_OFF;
        end else begin
          mode_q = PS_ON;
        end
      end
    endcase
    r.relay_on        = relay_q;
    r.electronics_on  = elec_q;
    r.thruster_killed = killed_q;
    r.filtered_level  = level_q;
    r.power_state     = mode_q;
  endtask

  task automatic check_field(input string name, input logic [LEVEL_BITS-1:0] want,
                             input logic [LEVEL_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Configuration first, then the accepted input word, then the result word, so a
  // result always meets the oldest word still owed.
  always @(posedge clk) begin
    pbsa_out_t predicted;
    pbsa_out_t due;
    if (!rst_n) begin
      reset_sequencer();
      sequencer_outputs_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BUS_THR:  bus_thr_q  = cfg_data;
          CFG_KILL_THR: kill_thr_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_sequencer(in_data, predicted);
        sequencer_outputs_due.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (sequencer_outputs_due.size() == 0) begin
          $display("%0t: result word %h arrived with nothing owed", $time, out_data);
          error_count++;
        end else begin
          due = sequencer_outputs_due.pop_front();
          results_checked++;
          check_field("relay_on", due.relay_on, out_data.relay_on);
          check_field("electronics_on", due.electronics_on, out_data.electronics_on);
          check_field("thruster_killed", due.thruster_killed, out_data.thruster_killed);
          check_field("filtered_level", due.filtered_level, out_data.filtered_level);
          check_field("power_state", due.power_state, out_data.power_state);
        end
      end
    end
    pending_words = sequencer_outputs_due.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Top of the power bus sequencer testbench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts every result word and
// compares it field by field.
module tb;
  import pbsa_pkg::*;

  localparam int unsigned RANDOM_WORDS_PER_SETTING = 150;
  localparam int unsigned SETTING_COUNT            = 7;
  localparam int unsigned DRAIN_CYCLES             = 8;
  localparam int unsigned CYCLE_LIMIT              = 400000;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX    = SAMPLE_BITS'(FULL_SCALE - 1);

  // An index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  // Receiver stall patterns, each held for a random stretch of cycles.
  typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_LONG} stall_mode_e;

  // Stimulus profiles. A quiet stretch keeps kill released and the switch steady
  // while the power samples sit low, so the window average can run down and trip
  // a shutdown on its own; the others stress the thresholds and the push buttons.
  typedef enum int {PROF_QUIET_LOW, PROF_NOMINAL, PROF_EDGE, PROF_NOISY} profile_e;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  pbsa_in_t                in_data;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  pbsa_out_t               out_data;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [SAMPLE_BITS-1:0]  cfg_data;

  int error_count;
  int pending_words;
  int results_checked;
  int good_startups;
  int refused_startups;
  int average_trips;

  // Handshake flags registered at the rising edge and read by the driver at the
  // falling edge, so the driver never races the block's own updates.
  logic        in_taken  = 1'b0;
  logic        cfg_taken = 1'b0;
  int unsigned cycle_count = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned burst_left = 0;
  profile_e    profile    = PROF_NOMINAL;
  int unsigned profile_left = 0;
  logic        remote_level = 1'b0;
  logic [SAMPLE_BITS-1:0] bus_thr_now  = BUS_THR_RESET;
  logic [SAMPLE_BITS-1:0] kill_thr_now = KILL_THR_RESET;
  int unsigned directed_words = 0;
  int unsigned random_words   = 0;

  power_bus_sequencer_with_average DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pbsa_tb_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .error_count      (error_count),
    .pending_words    (pending_words),
    .results_checked  (results_checked),
    .good_startups    (good_startups),
    .refused_startups (refused_startups),
    .average_trips    (average_trips)
  );

  // 20 ns clock, low first so the first rising edge falls at 10 ns.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Handshake flags and the run's watchdog.
  always @(posedge clk) begin
    in_taken    <= in_valid && !in_stall;
    cfg_taken   <= cfg_valid && cfg_ready;
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words owed", cycle_count, pending_words);
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls on a pattern of its own, independent of the sender. Every
  // pattern releases the channel again, so the end of the run drains.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(10, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_COIN:   out_stall <= ($urandom_range(0, 1) == 1);
      STALL_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
      default:      out_stall <= (stall_left % 8) < 5;
    endcase
  end

  function automatic pbsa_in_t tick(input int unsigned power, input int unsigned thruster,
                                    input logic kill, input logic remote);
    pbsa_in_t w;
    w.power_sample    = SAMPLE_BITS'(power);
    w.thruster_sample = SAMPLE_BITS'(thruster);
    w.kill_pressed    = kill;
    w.remote_active   = remote;
    return w;
  endfunction

  // A code within a few steps of a threshold, clamped to the converter range.
  function automatic logic [SAMPLE_BITS-1:0] near_value(input logic [SAMPLE_BITS-1:0] center);
    int x;
    x = int'(center) + int'($urandom_range(0, 16)) - 8;
    if (x < 0) x = 0;
    else if (x > int'(SAMPLE_MAX)) x = int'(SAMPLE_MAX);
    return SAMPLE_BITS'(x);
  endfunction

  // Presents one word at the current falling edge and returns at the falling edge
  // after it was taken. The payload holds still while the block stalls it.
  task automatic send_word(input pbsa_in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(negedge clk); while (!in_taken);
  endtask

  // Bursts of random length, mostly short, now and then long enough to run with
  // no gap at all; each burst ends in a gap that may also be empty.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Writes are issued back to back; the caller lowers cfg_valid after the last.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [SAMPLE_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_taken);
  endtask

  // Stops the sender and waits until every owed result word has been checked, then
  // waits out DRAIN_CYCLES so nothing is still on its way out of the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_word(output pbsa_in_t w);
    if (profile_left == 0) begin
      profile      = profile_e'($urandom_range(0, 3));
      profile_left = (profile == PROF_QUIET_LOW) ? $urandom_range(80, 200)
                                                 : $urandom_range(10, 60);
    end else begin
      profile_left--;
    end
    w.thruster_sample = ($urandom_range(0, 1) == 1) ? near_value(kill_thr_now)
                                                     : SAMPLE_BITS'($urandom);
    w.kill_pressed = 1'b0;
    case (profile)
      PROF_QUIET_LOW: begin
        // A few full-scale words in every 64 get the sequencer out of off again.
        w.power_sample = ((profile_left % 64) >= 60) ? SAMPLE_MAX
                                                     : SAMPLE_BITS'($urandom_range(0, 1200));
      end
      PROF_NOMINAL: begin
        w.power_sample = SAMPLE_BITS'($urandom_range(3000, int'(SAMPLE_MAX)));
        w.kill_pressed = ($urandom_range(0, 39) == 0);
        if ($urandom_range(0, 39) == 0) remote_level = !remote_level;
      end
      PROF_EDGE: begin
        w.power_sample = near_value(bus_thr_now);
        w.kill_pressed = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 9) == 0) remote_level = !remote_level;
      end
      default: begin
        w.power_sample = SAMPLE_BITS'($urandom);
        w.kill_pressed = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0) remote_level = !remote_level;
      end
    endcase
    w.remote_active = remote_level;
  endtask

  initial begin
    pbsa_in_t directed_list[$];
    pbsa_in_t w;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at the reset thresholds (bus 2688, kill 2533). They walk every
    // state, in and out by threshold, switch release and kill.
    directed_list.push_back(tick(0, 0, 1'b0, 1'b0));        // off, nothing happens
    directed_list.push_back(tick(2687, 4095, 1'b0, 1'b1));  // one below threshold; arm
    directed_list.push_back(tick(0, 0, 1'b0, 1'b0));        // switch release starts up
    directed_list.push_back(tick(0, 0, 1'b1, 1'b0));        // kill held: startup refused
    directed_list.push_back(tick(2688, 2533, 1'b0, 1'b0));  // exactly at threshold
    directed_list.push_back(tick(0, 0, 1'b0, 1'b1));        // startup succeeds, switch unseen
    directed_list.push_back(tick(4095, 2532, 1'b0, 1'b1));  // on: just below kill, killed
    directed_list.push_back(tick(4095, 2533, 1'b0, 1'b1));  // on: at kill threshold, alive
    directed_list.push_back(tick(4095, 4095, 1'b0, 1'b0));  // release in on: shutdown
    directed_list.push_back(tick(0, 0, 1'b0, 1'b0));        // shutdown opens the relay
    directed_list.push_back(tick(4095, 0, 1'b0, 1'b0));     // full scale starts up
    directed_list.push_back(tick(4095, 0, 1'b0, 1'b0));     // into on
    directed_list.push_back(tick(4095, 0, 1'b1, 1'b0));     // kill in on: shutdown
    directed_list.push_back(tick(4095, 0, 1'b1, 1'b0));     // kill is ignored in shutdown
    directed_list.push_back(tick(4095, 0, 1'b0, 1'b1));     // power starts up and arms
    directed_list.push_back(tick(0, 0, 1'b0, 1'b0));        // no release seen in startup
    directed_list.push_back(tick(0, 0, 1'b0, 1'b0));        // the release lands in on
    directed_list.push_back(tick(0, 4095, 1'b0, 1'b0));     // back to off
    directed_list.push_back(tick(4095, 4095, 1'b1, 1'b1));  // off with every bit set
    directed_list.push_back(tick(4095, 0, 1'b0, 1'b1));     // on, switch still held
    directed_list.push_back(tick(0, 0, 1'b0, 1'b1));        // zero sample lowers the average
    foreach (directed_list[i]) begin
      send_word(directed_list[i]);
      pace_sender();
      directed_words++;
    end
    wait_idle();

    // Random phases, each under its own pair of thresholds. The first two take the
    // extremes, the third returns to the reset values, the rest are random.
    for (int phase = 0; phase < SETTING_COUNT; phase++) begin
      case (phase)
        0: begin
          bus_thr_now  = '0;
          kill_thr_now = SAMPLE_MAX;
        end
        1: begin
          bus_thr_now  = SAMPLE_MAX;
          kill_thr_now = '0;
        end
        2: begin
          bus_thr_now  = BUS_THR_RESET;
          kill_thr_now = KILL_THR_RESET;
        end
        default: begin
          bus_thr_now  = SAMPLE_BITS'($urandom_range(1500, 3500));
          kill_thr_now = SAMPLE_BITS'($urandom);
        end
      endcase
      if (phase == 3) write_reg(CFG_SPARE, SAMPLE_BITS'($urandom));
      write_reg(CFG_BUS_THR, bus_thr_now);
      write_reg(CFG_KILL_THR, kill_thr_now);
      cfg_valid <= 1'b0;
      @(negedge clk);

      repeat (RANDOM_WORDS_PER_SETTING) begin
        random_word(w);
        send_word(w);
        pace_sender();
        random_words++;
      end
      wait_idle();
    end

    $display("Ran %0d directed and %0d random words over %0d threshold settings;",
             directed_words, random_words, SETTING_COUNT + 1);
    $display("%0d results checked, %0d good startups, %0d refused by kill, %0d low-average trips.",
             results_checked, good_startups, refused_startups, average_trips);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
